>>> rtl/wsh_pkg.sv
// Shared constants, register codes, configuration type and sine table builder.
package wsh_pkg;

  localparam int unsigned FracBitsDef      = 16;
  localparam int unsigned SineTableBitsDef = 10;
  localparam int unsigned InW              = 24;
  localparam int unsigned OutW             = 25;
  localparam int unsigned ShapeW           = 3;
  localparam int unsigned CfgIdxW          = 8;
  localparam int unsigned CfgDataW         = 3;

  // Wave shape codes; the two unused codes fall back to square.
  localparam logic [ShapeW-1:0] SHAPE_SINE    = 3'd0;
  localparam logic [ShapeW-1:0] SHAPE_COSINE  = 3'd1;
  localparam logic [ShapeW-1:0] SHAPE_TRIANGLE = 3'd2;
  localparam logic [ShapeW-1:0] SHAPE_SAW     = 3'd3;
  localparam logic [ShapeW-1:0] SHAPE_REV_SAW = 3'd4;
  localparam logic [ShapeW-1:0] SHAPE_SQUARE  = 3'd5;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_WAVE_SHAPE = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_NORMALIZE  = 8'd1;

  typedef struct packed {
    logic [ShapeW-1:0] shape;
    logic              normalize;
  } cfg_t;

  // Unsigned quotient by shift and subtract; used only while building the table.
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem_v;
    quo   = '0;
    rem_v = '0;
    for (int b = 63; b >= 0; b--) begin
      rem_v = {rem_v[63:0], num[b]};
      if (rem_v >= {1'b0, den}) begin
        rem_v  = rem_v - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // One quarter-wave entry: Taylor series in Q30, rounded to frac_bits.
  function automatic logic [24:0] sine_entry(int unsigned idx, int unsigned tbl_bits,
                                             int unsigned frac_bits);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] e;
    x    = (64'd1686629713 * 64'(idx)) >> tbl_bits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    for (int k = 1; k <= 8; k++) begin
      term = udiv64((term * x2) >> 30, 64'(2 * k) * 64'(2 * k + 1));
      if ((k & 1) == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    e = (sum + (64'sd1 <<< (29 - frac_bits))) >>> (30 - frac_bits);
    if (e > (64'sd1 <<< frac_bits)) begin
      e = 64'sd1 <<< frac_bits;
    end
    return e[24:0];
  endfunction

endpackage

>>> rtl/wsh_phase.sv
// Phase stages: product, fractional phase, sine table address and duty compare.
module wsh_phase import wsh_pkg::*; #(
  parameter int unsigned FracBits      = FracBitsDef,
  parameter int unsigned SineTableBits = SineTableBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  cfg_t                        cfg_i,
  input  logic signed [InW-1:0]       phase_i,
  input  logic signed [InW-1:0]       frequency_i,
  input  logic signed [InW-1:0]       phase_offset_i,
  input  logic signed [InW-1:0]       amplitude_i,
  input  logic signed [InW-1:0]       bias_i,
  input  logic signed [InW-1:0]       duty_cycle_i,
  output logic                        valid_o,
  output logic [FracBits-1:0]         q_o,
  output logic [SineTableBits:0]      addr_o,
  output logic                        neg_o,
  output logic                        duty_hit_o,
  output logic signed [InW-1:0]       amplitude_o,
  output logic signed [InW-1:0]       bias_o
);

  localparam int unsigned ProdW = 2 * InW;
  localparam int unsigned ZW    = 2 * FracBits;
  localparam int unsigned IdxW  = FracBits + SineTableBits + 2;
  localparam int unsigned AddrW = SineTableBits + 1;
  localparam int unsigned CmpW  = ((FracBits > InW) ? FracBits : InW) + 2;

  // Stage A: registered product and operands.
  logic                     v_a_q;
  logic signed [ProdW-1:0]  prod_a_q;
  logic signed [InW-1:0]    off_a_q, amp_a_q, bias_a_q, duty_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q <= 1'b0;
    end else begin
      v_a_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_a_q <= phase_i * frequency_i;
    off_a_q  <= phase_offset_i;
    amp_a_q  <= amplitude_i;
    bias_a_q <= bias_i;
    duty_a_q <= duty_cycle_i;
  end

  // Fractional phase: the sum modulo one, low half of the fraction dropped.
  logic [ZW-1:0]            z_sum;
  logic [FracBits-1:0]      q_d;
  logic [IdxW-1:0]          idx_sum;
  logic [1:0]               quad;
  logic [SineTableBits-1:0] rem;
  logic [AddrW-1:0]         addr_d;
  logic signed [CmpW-1:0]   q_ext, duty_ext;
  logic                     hit_d;

  always_comb begin
    z_sum   = prod_a_q[ZW-1:0] + {off_a_q[FracBits-1:0], {FracBits{1'b0}}};
    q_d     = z_sum[ZW-1:FracBits];
    // Round to the nearest of four times the table size steps.
    idx_sum = {q_d, {(SineTableBits + 2){1'b0}}} + (IdxW'(1) << (FracBits - 1));
    quad    = idx_sum[IdxW-1:IdxW-2] + ((cfg_i.shape == SHAPE_COSINE) ? 2'd1 : 2'd0);
    rem     = idx_sum[IdxW-3:FracBits];
    addr_d  = quad[0] ? ({1'b1, {SineTableBits{1'b0}}} - {1'b0, rem}) : {1'b0, rem};
    // Clamping of the duty cycle falls out of the signed compare.
    q_ext    = CmpW'({1'b0, q_d});
    duty_ext = CmpW'(duty_a_q);
    hit_d    = q_ext < duty_ext;
  end

  // Stage B.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= v_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    q_o         <= q_d;
    addr_o      <= addr_d;
    neg_o       <= quad[1];
    duty_hit_o  <= hit_d;
    amplitude_o <= amp_a_q;
    bias_o      <= bias_a_q;
  end

  a_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> addr_o <= {1'b1, {SineTableBits{1'b0}}})
    else $error("sine table address beyond quarter wave");

endmodule

>>> rtl/wsh_shape.sv
// Shape stages: quarter-wave table read, wave select and unit mapping.
module wsh_shape import wsh_pkg::*; #(
  parameter int unsigned FracBits      = FracBitsDef,
  parameter int unsigned SineTableBits = SineTableBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cfg_t                        cfg_i,
  input  logic                        valid_i,
  input  logic [FracBits-1:0]         q_i,
  input  logic [SineTableBits:0]      addr_i,
  input  logic                        neg_i,
  input  logic                        duty_hit_i,
  input  logic signed [InW-1:0]       amplitude_i,
  input  logic signed [InW-1:0]       bias_i,
  output logic                        valid_o,
  output logic signed [FracBits+2:0]  wave2_o,
  output logic signed [InW-1:0]       amplitude_o,
  output logic signed [InW-1:0]       bias_o
);

  localparam int unsigned TblN = 1 << SineTableBits;
  localparam int unsigned WW   = FracBits + 4;
  localparam logic signed [WW-1:0] One  = WW'(1) <<< FracBits;
  localparam logic signed [WW-1:0] Half = WW'(1) <<< (FracBits - 1);

  // Quarter-wave table, built at elaboration.
  logic [FracBits:0] sine_rom [TblN+1];

  for (genvar g = 0; g <= TblN; g++) begin : g_rom
    localparam logic [24:0] SineVal = sine_entry(g, SineTableBits, FracBits);
    assign sine_rom[g] = SineVal[FracBits:0];
  end

  // Stage C: table read plus forwarded operands.
  logic                   v_c_q, neg_c_q, hit_c_q;
  logic [FracBits:0]      rom_c_q;
  logic [FracBits-1:0]    q_c_q;
  logic signed [InW-1:0]  amp_c_q, bias_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_c_q <= 1'b0;
    end else begin
      v_c_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rom_c_q  <= sine_rom[addr_i];
    q_c_q    <= q_i;
    neg_c_q  <= neg_i;
    hit_c_q  <= duty_hit_i;
    amp_c_q  <= amplitude_i;
    bias_c_q <= bias_i;
  end

  logic signed [WW-1:0] q_s, rom_s, tri_dist, wave, wave2;

  always_comb begin
    q_s      = WW'({1'b0, q_c_q});
    rom_s    = WW'({1'b0, rom_c_q});
    tri_dist = q_s - Half;
    if (tri_dist < 0) begin
      tri_dist = -tri_dist;
    end
    case (cfg_i.shape) inside
      SHAPE_SINE, SHAPE_COSINE: wave = neg_c_q ? -rom_s : rom_s;
      SHAPE_TRIANGLE:           wave = One - (tri_dist <<< 2);
      SHAPE_SAW:                wave = (q_s <<< 1) - One;
      SHAPE_REV_SAW:            wave = One - (q_s <<< 1);
      default:                  wave = hit_c_q ? One : -One;
    endcase
    // One extra fraction bit keeps the unit mapping exact.
    wave2 = cfg_i.normalize ? (wave + One) : (wave <<< 1);
  end

  // Stage D.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= v_c_q;
    end
  end

  always_ff @(posedge clk_i) begin
    wave2_o     <= wave2[FracBits+2:0];
    amplitude_o <= amp_c_q;
    bias_o      <= bias_c_q;
  end

  a_unit_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && cfg_i.normalize |-> wave2_o >= 0)
    else $error("normalized wave below zero");

endmodule

>>> rtl/wsh_scale.sv
// Scale stages: gain multiply, bias add, round to nearest and saturate.
module wsh_scale import wsh_pkg::*; #(
  parameter int unsigned FracBits = FracBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic signed [FracBits+2:0]  wave2_i,
  input  logic signed [InW-1:0]       amplitude_i,
  input  logic signed [InW-1:0]       bias_i,
  output logic                        valid_o,
  output logic signed [OutW-1:0]      wave_value_o
);

  localparam int unsigned PW   = FracBits + 3 + InW;
  localparam int unsigned AccW = PW + 1;
  localparam logic signed [AccW-1:0] ResMax = AccW'((1 << (OutW - 1)) - 1);
  localparam logic signed [AccW-1:0] ResMin = -ResMax - AccW'(1);

  // Stage E: registered gain product.
  logic                   v_e_q;
  logic signed [PW-1:0]   prod_e_q;
  logic signed [InW-1:0]  bias_e_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_e_q <= 1'b0;
    end else begin
      v_e_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_e_q <= wave2_i * amplitude_i;
    bias_e_q <= bias_i;
  end

  logic signed [AccW-1:0] acc, res;
  logic signed [OutW-1:0] wave_value_d;

  always_comb begin
    acc = AccW'(prod_e_q) + (AccW'(bias_e_q) <<< (FracBits + 1))
        + (AccW'(1) <<< FracBits);
    res = acc >>> (FracBits + 1);
    if (res > ResMax) begin
      wave_value_d = ResMax[OutW-1:0];
    end else if (res < ResMin) begin
      wave_value_d = ResMin[OutW-1:0];
    end else begin
      wave_value_d = res[OutW-1:0];
    end
  end

  // Stage F: output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= v_e_q;
    end
  end

  always_ff @(posedge clk_i) begin
    wave_value_o <= wave_value_d;
  end

endmodule

>>> rtl/waveform_shaper.sv
// Six register stages (A to F) lie between start and the wave_valid_o strobe, the same for every shape.
// Throughput: one item per cycle; busy stays low, so start may be held high.
// Depth is set by two multipliers (phase product, gain) and the table read stage.
// Reset clears the valid bits of all six stages and both config registers.
// Results cannot be held off: each strobe shows its sample for one cycle only.
module waveform_shaper import wsh_pkg::*; #(
  parameter int unsigned FracBits      = FracBitsDef,
  parameter int unsigned SineTableBits = SineTableBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [InW-1:0]      phase_i,
  input  logic signed [InW-1:0]      frequency_i,
  input  logic signed [InW-1:0]      phase_offset_i,
  input  logic signed [InW-1:0]      amplitude_i,
  input  logic signed [InW-1:0]      bias_i,
  input  logic signed [InW-1:0]      duty_cycle_i,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CfgIdxW-1:0]         cfg_index_i,
  input  logic [CfgDataW-1:0]        cfg_data_i,
  output logic                       wave_valid_o,
  output logic signed [OutW-1:0]     wave_value_o
);

  localparam int unsigned Latency = 6;

  // The pipeline never stalls, so an item is taken whenever start is high.
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  logic accept;
  assign accept = start && !busy;

  // Configuration registers; unused data bits and unknown indexes are dropped.
  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_WAVE_SHAPE: cfg_d.shape     = cfg_data_i;
        REG_NORMALIZE:  cfg_d.normalize = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Phase front end: stages A and B.
  logic                        v_b;
  logic [FracBits-1:0]         q_b;
  logic [SineTableBits:0]      addr_b;
  logic                        neg_b, hit_b;
  logic signed [InW-1:0]       amp_b, bias_b;

  wsh_phase #(
    .FracBits      (FracBits),
    .SineTableBits (SineTableBits)
  ) u_phase (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (accept),
    .cfg_i          (cfg_q),
    .phase_i        (phase_i),
    .frequency_i    (frequency_i),
    .phase_offset_i (phase_offset_i),
    .amplitude_i    (amplitude_i),
    .bias_i         (bias_i),
    .duty_cycle_i   (duty_cycle_i),
    .valid_o        (v_b),
    .q_o            (q_b),
    .addr_o         (addr_b),
    .neg_o          (neg_b),
    .duty_hit_o     (hit_b),
    .amplitude_o    (amp_b),
    .bias_o         (bias_b)
  );

  // Wave select: stages C and D.
  logic                        v_d;
  logic signed [FracBits+2:0]  wave2_d;
  logic signed [InW-1:0]       amp_d, bias_d;

  wsh_shape #(
    .FracBits      (FracBits),
    .SineTableBits (SineTableBits)
  ) u_shape (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .valid_i     (v_b),
    .q_i         (q_b),
    .addr_i      (addr_b),
    .neg_i       (neg_b),
    .duty_hit_i  (hit_b),
    .amplitude_i (amp_b),
    .bias_i      (bias_b),
    .valid_o     (v_d),
    .wave2_o     (wave2_d),
    .amplitude_o (amp_d),
    .bias_o      (bias_d)
  );

  // Gain, bias and rounding: stages E and F.
  wsh_scale #(
    .FracBits (FracBits)
  ) u_scale (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (v_d),
    .wave2_i      (wave2_d),
    .amplitude_i  (amp_d),
    .bias_i       (bias_d),
    .valid_o      (wave_valid_o),
    .wave_value_o (wave_value_o)
  );

  a_accept_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##Latency wave_valid_o)
    else $error("accepted item produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |-> ##Latency !wave_valid_o)
    else $error("result strobe without accepted item");

endmodule
